[hw/rtl/rrfpt_pkg.sv]
// shared types and constants for the receive ring fifo with peek and idle timeout
`default_nettype none
package rrfpt_pkg;

	localparam int unsigned DEPTH_DEF = 64;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned SPAN_W    = 6;
	localparam int unsigned FILL_W    = 6;
	localparam int unsigned ACT_W     = 3;
	localparam int unsigned STAT_W    = 3;

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH   = 3'd0,
		ACT_POP    = 3'd1,
		ACT_PEEK   = 3'd2,
		ACT_WINDOW = 3'd3,
		ACT_DROP   = 3'd4,
		ACT_TICK   = 3'd5
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 3'd0,
		ST_REFUSED  = 3'd1,
		ST_OVERFLOW = 3'd2,
		ST_TIMEOUT  = 3'd3,
		ST_TICK     = 3'd4
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_EXEC  = 5'b00010,
		S_READ  = 5'b00100,
		S_RDATA = 5'b01000,
		S_OUT   = 5'b10000
	} state_t;

endpackage
`default_nettype wire

[hw/rtl/rrfpt_wrap_add.sv]
// shared pointer adder: adds a step to a ring index and wraps modulo DEPTH
`default_nettype none
module rrfpt_wrap_add
	import rrfpt_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  wire logic [$clog2(DEPTH)-1:0] base,
	input  wire logic [SPAN_W-1:0]        step,
	output logic      [$clog2(DEPTH)-1:0] sum
);

	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned SUM_W = ((IDX_W > SPAN_W) ? IDX_W : SPAN_W) + 1;

	logic [SUM_W-1:0] raw;
	logic [SUM_W-1:0] wrapped;

	// operands keep base + step below twice the depth, so one subtract wraps it
	always_comb begin
		raw     = SUM_W'(base) + SUM_W'(step);
		wrapped = (raw >= SUM_W'(DEPTH)) ? (raw - SUM_W'(DEPTH)) : raw;
		sum     = wrapped[IDX_W-1:0];
	end

endmodule
`default_nettype wire

[hw/rtl/rx_ring_fifo_peek_timeout.sv]
// receive ring fifo with pop, peek, window peek, drop and idle timeout
// sequence: push, drop, tick or a refused request go from S_EXEC to S_OUT; pop, peek and
// the first window byte also pass S_READ and S_RDATA; later window bytes repeat S_READ, S_RDATA
// one item at a time: a new item is taken only after the last result is accepted, paced by
// the sequencer around the single pointer adder and the registered store read port
// reset: arst_n clears pointers, count, idle timer and timeout register; store is not cleared
`default_nettype none
module rx_ring_fifo_peek_timeout
	import rrfpt_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [BYTE_W-1:0]   cfg_wdata,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [ACT_W-1:0]    action,
	input  wire logic [BYTE_W-1:0]   rx_byte,
	input  wire logic [SPAN_W-1:0]   offset,
	input  wire logic [SPAN_W-1:0]   amount,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [STAT_W-1:0]        status,
	output logic [BYTE_W-1:0]        out_byte,
	output logic [FILL_W-1:0]        fill,
	output logic                     last
);

	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned CMP_W = ((IDX_W > SPAN_W + 1) ? IDX_W : SPAN_W + 1) + 1;

	state_t             state_q;
	action_t            act_q;
	logic [BYTE_W-1:0]  byte_q;
	logic [SPAN_W-1:0]  off_q;
	logic [SPAN_W-1:0]  amt_q;
	logic [SPAN_W-1:0]  rem_q;
	logic [IDX_W-1:0]   head_q;
	logic [IDX_W-1:0]   tail_q;
	logic [IDX_W-1:0]   ptr_q;
	logic [IDX_W-1:0]   held_q;
	logic [BYTE_W-1:0]  idle_q;
	logic [BYTE_W-1:0]  timeout_q;
	status_t            status_q;
	logic [BYTE_W-1:0]  out_byte_q;
	logic               last_q;
	logic [BYTE_W-1:0]  rdata_q;
	logic [BYTE_W-1:0]  store [DEPTH];

	logic [IDX_W-1:0]   alu_base;
	logic [SPAN_W-1:0]  alu_step;
	logic [IDX_W-1:0]   alu_sum;
	logic               store_we;
	logic               full;
	logic               empty;
	logic               win_bad;
	logic               drop_bad;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign status    = status_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;
	assign fill      = FILL_W'(held_q);

	assign full     = (held_q == IDX_W'(DEPTH - 1));
	assign empty    = (held_q == '0);
	assign win_bad  = empty || (amt_q == '0)
		|| ((CMP_W'(off_q) + CMP_W'(amt_q)) > CMP_W'(held_q));
	assign drop_bad = (CMP_W'(amt_q) > CMP_W'(held_q));
	assign store_we = (state_q == S_EXEC) && (act_q == ACT_PUSH) && !full;

	// operand select for the one pointer adder
	always_comb begin
		alu_base = head_q;
		alu_step = SPAN_W'(1);
		if (state_q == S_READ) begin
			alu_base = ptr_q;
		end else begin
			case (act_q)
				ACT_PUSH:   alu_base = tail_q;
				ACT_DROP:   alu_step = amt_q;
				ACT_WINDOW: alu_step = off_q;
				default:    alu_step = SPAN_W'(1);
			endcase
		end
	end

	rrfpt_wrap_add #(
		.DEPTH (DEPTH)
	) u_add (
		.base (alu_base),
		.step (alu_step),
		.sum  (alu_sum)
	);

	always_ff @(posedge clk) begin
		if (store_we) begin
			store[tail_q] <= byte_q;
		end
		if (state_q == S_READ) begin
			rdata_q <= store[ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= '0;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			act_q  <= action_t'(action);
			byte_q <= rx_byte;
			off_q  <= offset;
			amt_q  <= amount;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_q     <= '0;
			tail_q     <= '0;
			held_q     <= '0;
			idle_q     <= '0;
			ptr_q      <= '0;
			rem_q      <= '0;
			status_q   <= ST_OK;
			out_byte_q <= '0;
			last_q     <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					status_q   <= ST_OK;
					out_byte_q <= '0;
					last_q     <= 1'b1;
					rem_q      <= '0;
					state_q    <= S_OUT;
					case (act_q)
						ACT_PUSH: begin
							if (full) begin
								status_q <= ST_OVERFLOW;
							end else begin
								tail_q <= alu_sum;
								held_q <= held_q + IDX_W'(1);
								idle_q <= timeout_q;
							end
						end
						ACT_POP, ACT_PEEK: begin
							if (empty) begin
								status_q <= ST_REFUSED;
							end else begin
								ptr_q   <= head_q;
								state_q <= S_READ;
								if (act_q == ACT_POP) begin
									head_q <= alu_sum;
									held_q <= held_q - IDX_W'(1);
								end
							end
						end
						ACT_WINDOW: begin
							if (win_bad) begin
								status_q <= ST_REFUSED;
							end else begin
								ptr_q   <= alu_sum;
								rem_q   <= amt_q - SPAN_W'(1);
								state_q <= S_READ;
							end
						end
						ACT_DROP: begin
							if (drop_bad) begin
								status_q <= ST_REFUSED;
							end else begin
								head_q <= alu_sum;
								held_q <= held_q - IDX_W'(amt_q);
							end
						end
						ACT_TICK: begin
							status_q <= ST_TICK;
							if (idle_q != '0) begin
								idle_q <= idle_q - BYTE_W'(1);
								if (idle_q == BYTE_W'(1)) begin
									status_q <= ST_TIMEOUT;
								end
							end
						end
						default: status_q <= ST_REFUSED;
					endcase
				end
				S_READ: begin
					// read issued at ptr_q, advance for the next window byte
					ptr_q   <= alu_sum;
					state_q <= S_RDATA;
				end
				S_RDATA: begin
					status_q   <= ST_OK;
					out_byte_q <= rdata_q;
					last_q     <= (rem_q == '0);
					state_q    <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) begin
						if (last_q) begin
							state_q <= S_IDLE;
						end else begin
							rem_q   <= rem_q - SPAN_W'(1);
							state_q <= S_READ;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[hw/rtl/rrfpt_checker.sv]
// port-level checks for the receive ring fifo, bound to the top level
`default_nettype none
module rrfpt_checker
	import rrfpt_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire logic [STAT_W-1:0]   status,
	input wire logic [BYTE_W-1:0]   out_byte,
	input wire logic [FILL_W-1:0]   fill,
	input wire logic                last
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_byte)
			&& $stable(fill) && $stable(last))
		else $error("result changed while stalled");

	// one item at a time: no new transfer while a result is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while result pending");

	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready && !out_valid)
		else $error("not busy after input transfer");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= STAT_W'(ST_TICK))
		else $error("status code out of range");

	a_fail_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_W'(ST_OK) |-> last && out_byte == '0)
		else $error("non-ok result not single or carries a byte");

endmodule

bind rx_ring_fifo_peek_timeout rrfpt_checker u_rrfpt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.status    (status),
	.out_byte  (out_byte),
	.fill      (fill),
	.last      (last)
);
`default_nettype wire
